@@ rtl/thick_line_rasterizer_core_macros.svh @@
// Assertion macros shared by the rasterizer checker.
`ifndef THICK_LINE_RASTERIZER_CORE_MACROS_SVH
`define THICK_LINE_RASTERIZER_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define THLR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define THLR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/thlr_pkg.sv @@
// Shared types and constants for the thick line rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package thlr_pkg;

  // Request command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Two's complement direction codes
  localparam logic [1:0] DIR_ZERO = 2'd0;
  localparam logic [1:0] DIR_POS  = 2'd1;
  localparam logic [1:0] DIR_NEG  = 2'd3;

  // Width of the coordinate ports
  localparam int PORT_COORD_W = 16;

  // Control flags of one step's pixel run
  typedef struct packed {
    logic pix_valid;  // line was active, coordinates meaningful
    logic horiz;      // horizontal-major run order
    logic done;       // this step used up the line, or no line was active
  } run_ctl_t;

endpackage

`default_nettype wire

@@ rtl/thlr_step.sv @@
// Line state registers and the Bresenham step / line setup logic.
`timescale 1ns / 1ps
`default_nettype none

module thlr_step import thlr_pkg::*; #(
  parameter int MAX_THICKNESS = 32,
  parameter int COORD_BITS    = 16,
  parameter int KW            = $clog2(2 * MAX_THICKNESS)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      take,
  input  wire logic                      cmd,
  input  wire logic [PORT_COORD_W-1:0]   start_x,
  input  wire logic [PORT_COORD_W-1:0]   start_y,
  input  wire logic [PORT_COORD_W-1:0]   end_x,
  input  wire logic [PORT_COORD_W-1:0]   end_y,
  input  wire logic [15:0]               line_color,
  input  wire logic [5:0]                line_width,
  output run_ctl_t                       run_ctl,
  output logic [COORD_BITS-1:0]          run_x,
  output logic [COORD_BITS-1:0]          run_y,
  output logic [15:0]                    run_color,
  output logic [KW-1:0]                  run_last
);

  localparam int CB  = COORD_BITS;
  localparam int ERW = COORD_BITS + 1;

  // Line state
  logic            active;
  logic [CB-1:0]   cur_x;
  logic [CB-1:0]   cur_y;
  logic [ERW-1:0]  err_acc;
  logic [ERW-1:0]  abs_dx;
  logic [ERW-1:0]  abs_dy;
  logic [1:0]      dir_x;
  logic [1:0]      dir_y;
  logic            horiz_major;
  logic [ERW-1:0]  steps_left;
  logic [15:0]     held_color;
  logic [KW-1:0]   held_last;

  function automatic logic [CB-1:0] dir_addend(input logic [1:0] d);
    logic [CB-1:0] r;
    case (d)
      DIR_POS: r = CB'(1);
      DIR_NEG: r = '1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Setup of a new line
  logic [CB-1:0]  sx, sy, ex, ey;
  logic [ERW-1:0] dx, dy, adx, ady, s_major;
  logic           s_horiz;
  logic [5:0]     w_sat, w_sides;
  logic [6:0]     w_last;

  always_comb begin
    sx = start_x[CB-1:0];
    sy = start_y[CB-1:0];
    ex = end_x[CB-1:0];
    ey = end_y[CB-1:0];
    dx = {ex[CB-1], ex} - {sx[CB-1], sx};
    dy = {ey[CB-1], ey} - {sy[CB-1], sy};
    adx = dx[CB] ? (~dx + 1'b1) : dx;
    ady = dy[CB] ? (~dy + 1'b1) : dy;
    s_horiz = adx >= ady;
    s_major = s_horiz ? adx : ady;
    w_sat = (line_width > 6'(MAX_THICKNESS)) ? 6'(MAX_THICKNESS) : line_width;
    w_sides = (w_sat > 6'd1) ? (w_sat - 6'd1) : 6'd0;
    w_last = {w_sides, 1'b0};
  end

  // One Bresenham step along the major axis
  logic [ERW-1:0] maj, mnr;
  logic [ERW:0]   err_sum;
  logic           bump;
  logic [ERW-1:0] err_next;
  logic [CB-1:0]  x_next, y_next;
  logic [ERW-1:0] steps_next;
  logic           done_next;

  always_comb begin
    maj = horiz_major ? abs_dx : abs_dy;
    mnr = horiz_major ? abs_dy : abs_dx;
    err_sum = {1'b0, err_acc} + {1'b0, mnr};
    bump = err_sum >= {1'b0, maj};
    err_next = bump ? ERW'(err_sum - {1'b0, maj}) : ERW'(err_sum);
    x_next = (horiz_major || bump) ? (cur_x + dir_addend(dir_x)) : cur_x;
    y_next = (!horiz_major || bump) ? (cur_y + dir_addend(dir_y)) : cur_y;
    steps_next = steps_left - 1'b1;
    done_next = steps_next == '0;
  end

  // Run handed to the pixel emitter for a step request
  always_comb begin
    run_ctl.pix_valid = active;
    run_ctl.horiz = horiz_major;
    run_ctl.done = active ? done_next : 1'b1;
    run_x = active ? x_next : '0;
    run_y = active ? y_next : '0;
    run_color = active ? held_color : '0;
    run_last = active ? held_last : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cur_x <= '0;
      cur_y <= '0;
      err_acc <= '0;
      abs_dx <= '0;
      abs_dy <= '0;
      dir_x <= DIR_ZERO;
      dir_y <= DIR_ZERO;
      horiz_major <= 1'b0;
      steps_left <= '0;
      held_color <= '0;
      held_last <= '0;
    end else if (take) begin
      if (cmd == CMD_START) begin
        abs_dx <= adx;
        abs_dy <= ady;
        dir_x <= (dx == '0) ? DIR_ZERO : (dx[CB] ? DIR_NEG : DIR_POS);
        dir_y <= (dy == '0) ? DIR_ZERO : (dy[CB] ? DIR_NEG : DIR_POS);
        cur_x <= sx;
        cur_y <= sy;
        horiz_major <= s_horiz;
        steps_left <= s_major;
        err_acc <= s_major >> 1;
        held_color <= line_color;
        held_last <= KW'(w_last);
        active <= s_major != '0;
      end else if (active) begin
        err_acc <= err_next;
        cur_x <= x_next;
        cur_y <= y_next;
        steps_left <= steps_next;
        active <= !done_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/thlr_emit.sv @@
// Pixel run register and output register: one pixel of the run per cycle while the output is not stalled.
`timescale 1ns / 1ps
`default_nettype none

module thlr_emit import thlr_pkg::*; #(
  parameter int MAX_THICKNESS = 32,
  parameter int COORD_BITS    = 16,
  parameter int KW            = $clog2(2 * MAX_THICKNESS)
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     load,
  input  run_ctl_t                      ld_ctl,
  input  wire logic [COORD_BITS-1:0]    ld_x,
  input  wire logic [COORD_BITS-1:0]    ld_y,
  input  wire logic [15:0]              ld_color,
  input  wire logic [KW-1:0]            ld_last,
  output logic                          can_load,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          pixel_valid,
  output logic signed [PORT_COORD_W-1:0] pixel_x,
  output logic signed [PORT_COORD_W-1:0] pixel_y,
  output logic [15:0]                   pixel_color,
  output logic                          last_of_step,
  output logic                          line_done
);

  localparam int CB = COORD_BITS;

  // Current run
  logic                busy;
  logic [KW-1:0]       k;
  logic [KW-1:0]       last;
  run_ctl_t            ctl;
  logic [CB-1:0]       cx;
  logic [CB-1:0]       cy;
  logic [15:0]         color;

  logic          out_free, emit_now, run_end;
  logic          is_last, is_center, neg_side;
  logic [KW:0]   j_wide;
  logic [CB-1:0] j, off, px, py;

  always_comb begin
    out_free = !out_valid || !out_stall;
    emit_now = busy && out_free;
    is_last = k == last;
    run_end = emit_now && is_last;
    can_load = !busy || run_end;
  end

  // Pixel k of the run: center, then +j/-j pairs (vertical: pairs first)
  always_comb begin
    if (ctl.horiz) begin
      j_wide = ({1'b0, k} + 1'b1) >> 1;
      neg_side = !k[0] && (k != '0);
      is_center = k == '0;
    end else begin
      j_wide = ({1'b0, k} >> 1) + 1'b1;
      neg_side = k[0];
      is_center = is_last;
    end
    j = CB'(j_wide);
    off = neg_side ? (~j + 1'b1) : j;
    px = cx;
    py = cy;
    if (!is_center) begin
      if (ctl.horiz) begin
        py = cy + off;
      end else begin
        px = cx + off;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      k <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        busy <= 1'b1;
        k <= '0;
      end else if (run_end) begin
        busy <= 1'b0;
      end else if (emit_now) begin
        k <= k + 1'b1;
      end
      if (emit_now) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Run payload
  always_ff @(posedge clk) begin
    if (load) begin
      ctl <= ld_ctl;
      cx <= ld_x;
      cy <= ld_y;
      color <= ld_color;
      last <= ld_last;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (emit_now) begin
      pixel_valid <= ctl.pix_valid;
      pixel_x <= PORT_COORD_W'(signed'(px));
      pixel_y <= PORT_COORD_W'(signed'(py));
      pixel_color <= color;
      last_of_step <= is_last;
      line_done <= ctl.done;
    end
  end

endmodule

`default_nettype wire

@@ rtl/thick_line_rasterizer_core.sv @@
// A step request enters the run register when accepted; its first pixel moves
// to the output register once that register is free. A start request emits
// nothing; a step request emits 1 + 2*(w-1) pixels for thickness w above 1 (w
// capped at MAX_THICKNESS), else 1, or one result if no line is active, all on
// the single pixel output port. A new request waits for the run's last pixel.
// Reset: synchronous; clears the line state (no active line), busy, out_valid.
`timescale 1ns / 1ps
`default_nettype none

module thick_line_rasterizer_core import thlr_pkg::*; #(
  parameter int MAX_THICKNESS = 32,
  parameter int COORD_BITS    = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      cmd,
  input  wire logic signed [PORT_COORD_W-1:0] start_x,
  input  wire logic signed [PORT_COORD_W-1:0] start_y,
  input  wire logic signed [PORT_COORD_W-1:0] end_x,
  input  wire logic signed [PORT_COORD_W-1:0] end_y,
  input  wire logic [15:0]               line_color,
  input  wire logic [5:0]                line_width,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           pixel_valid,
  output logic signed [PORT_COORD_W-1:0] pixel_x,
  output logic signed [PORT_COORD_W-1:0] pixel_y,
  output logic [15:0]                    pixel_color,
  output logic                           last_of_step,
  output logic                           line_done
);

  localparam int KW = $clog2(2 * MAX_THICKNESS);

  logic                  take;
  logic                  step_load;
  logic                  can_load;
  run_ctl_t              run_ctl;
  logic [COORD_BITS-1:0] run_x;
  logic [COORD_BITS-1:0] run_y;
  logic [15:0]           run_color;
  logic [KW-1:0]         run_last;

  // Request handshake
  assign in_stall = !can_load;
  assign take = in_valid && can_load;
  assign step_load = take && (cmd == CMD_STEP);

  thlr_step #(
    .MAX_THICKNESS(MAX_THICKNESS),
    .COORD_BITS(COORD_BITS),
    .KW(KW)
  ) u_step (
    .clk(clk),
    .rst(rst),
    .take(take),
    .cmd(cmd),
    .start_x(start_x),
    .start_y(start_y),
    .end_x(end_x),
    .end_y(end_y),
    .line_color(line_color),
    .line_width(line_width),
    .run_ctl(run_ctl),
    .run_x(run_x),
    .run_y(run_y),
    .run_color(run_color),
    .run_last(run_last)
  );

  thlr_emit #(
    .MAX_THICKNESS(MAX_THICKNESS),
    .COORD_BITS(COORD_BITS),
    .KW(KW)
  ) u_emit (
    .clk(clk),
    .rst(rst),
    .load(step_load),
    .ld_ctl(run_ctl),
    .ld_x(run_x),
    .ld_y(run_y),
    .ld_color(run_color),
    .ld_last(run_last),
    .can_load(can_load),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pixel_valid(pixel_valid),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .pixel_color(pixel_color),
    .last_of_step(last_of_step),
    .line_done(line_done)
  );

endmodule

`default_nettype wire

@@ rtl/thlr_check.sv @@
// Port-level checker for the rasterizer core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "thick_line_rasterizer_core_macros.svh"

module thlr_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        cmd,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        pixel_valid,
  input wire logic [15:0] pixel_x,
  input wire logic [15:0] pixel_y,
  input wire logic        last_of_step,
  input wire logic        line_done
);

  // A stalled pixel holds
  `THLR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(pixel_x) && $stable(pixel_y), "stalled pixel changed")

  // A step with no active line is a lone result closing the line
  `THLR_ASSERT_NOW(a_idle_step, clk, rst, out_valid && !pixel_valid, last_of_step && line_done, "invalid result not flagged last and done")

  // An accepted step request always yields a result on the output
  `THLR_ASSERT_NEXT(a_step_out, clk, rst, in_valid && !in_stall && cmd, ##1 out_valid, "step request gave no result")

  // A run continues without gaps once a pixel is taken
  `THLR_ASSERT_NEXT(a_run_gapless, clk, rst, out_valid && !out_stall && !last_of_step, out_valid, "gap inside a pixel run")

endmodule

bind thick_line_rasterizer_core thlr_check u_check (.*);

`default_nettype wire

@@ tb/sv/tb_thick_line_rasterizer_core.sv @@
// Self-checking testbench for the thick line rasterizer core with a built-in pixel predictor.
`timescale 1ns / 1ps

module tb_thick_line_rasterizer_core;
  import thlr_pkg::*;

  localparam int MAX_W        = 32;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PATTERN, STALL_HEAVY} stall_mode_t;

  typedef struct packed {
    logic                           valid;
    logic signed [PORT_COORD_W-1:0] x;
    logic signed [PORT_COORD_W-1:0] y;
    logic [15:0]                    color;
    logic                           last;
    logic                           done;
  } pixel_t;

  // DUT connections, all inputs known from time zero
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic cmd = CMD_START;
  logic signed [PORT_COORD_W-1:0] start_x = '0;
  logic signed [PORT_COORD_W-1:0] start_y = '0;
  logic signed [PORT_COORD_W-1:0] end_x = '0;
  logic signed [PORT_COORD_W-1:0] end_y = '0;
  logic [15:0] line_color = '0;
  logic [5:0] line_width = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic pixel_valid;
  logic signed [PORT_COORD_W-1:0] pixel_x;
  logic signed [PORT_COORD_W-1:0] pixel_y;
  logic [15:0] pixel_color;
  logic last_of_step;
  logic line_done;

  thick_line_rasterizer_core uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .line_color   (line_color),
    .line_width   (line_width),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_valid  (pixel_valid),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pixel_color  (pixel_color),
    .last_of_step (last_of_step),
    .line_done    (line_done)
  );

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted line state
  logic                    ln_active = 1'b0;
  logic [PORT_COORD_W-1:0] ln_x = '0;
  logic [PORT_COORD_W-1:0] ln_y = '0;
  logic [16:0]             ln_err = '0;
  logic [16:0]             ln_adx = '0;
  logic [16:0]             ln_ady = '0;
  logic [1:0]              ln_dirx = DIR_ZERO;
  logic [1:0]              ln_diry = DIR_ZERO;
  logic                    ln_horiz = 1'b0;
  logic [16:0]             ln_left = '0;
  logic [15:0]             ln_color = '0;
  logic [5:0]              ln_width = '0;

  pixel_t pending_pixels[$];
  pixel_t want;

  // Run bookkeeping
  int fail_count = 0;
  int cycle_count = 0;
  int n_starts = 0;
  int n_steps = 0;
  int n_pixels = 0;
  int n_blank = 0;

  // Sender and receiver pacing
  stall_mode_t stall_mode = STALL_NONE;
  bit gaps_on = 1'b1;
  int burst_left = 0;
  int hold_tickets = 0;

  function automatic logic [PORT_COORD_W-1:0] dir_offset(input logic [1:0] d);
    case (d)
      DIR_POS: return 16'd1;
      DIR_NEG: return 16'hFFFF;
      default: return 16'd0;
    endcase
  endfunction

  function automatic pixel_t make_pixel(input logic v, input logic [15:0] x, y, col,
                                        input logic last, done);
    pixel_t p;
    p.valid = v;
    p.x = x;
    p.y = y;
    p.color = col;
    p.last = last;
    p.done = done;
    return p;
  endfunction

  // Update the predicted line state for one request and queue its pixels
  task automatic predict_pixels(input logic c, input logic signed [15:0] sx, sy, ex, ey,
                                input logic [15:0] col, input logic [5:0] w);
    int dx, dy, sides, n, k, j;
    logic done;
    if (c == CMD_START) begin
      dx = int'(ex) - int'(sx);
      dy = int'(ey) - int'(sy);
      ln_adx = 17'(dx < 0 ? -dx : dx);
      ln_ady = 17'(dy < 0 ? -dy : dy);
      ln_dirx = dx > 0 ? DIR_POS : (dx < 0 ? DIR_NEG : DIR_ZERO);
      ln_diry = dy > 0 ? DIR_POS : (dy < 0 ? DIR_NEG : DIR_ZERO);
      ln_x = sx;
      ln_y = sy;
      ln_horiz = ln_adx >= ln_ady;
      ln_left = ln_horiz ? ln_adx : ln_ady;
      ln_err = ln_left >> 1;
      ln_color = col;
      ln_width = (w > MAX_W) ? 6'(MAX_W) : w;
      ln_active = ln_left != 0;
    end else if (!ln_active) begin
      pending_pixels.push_back(make_pixel(1'b0, '0, '0, '0, 1'b1, 1'b1));
    end else begin
      // Bresenham advance along the major axis
      if (ln_horiz) begin
        ln_err = ln_err + ln_ady;
        if (ln_err >= ln_adx) begin
          ln_err = ln_err - ln_adx;
          ln_y = ln_y + dir_offset(ln_diry);
        end
        ln_x = ln_x + dir_offset(ln_dirx);
      end else begin
        ln_err = ln_err + ln_adx;
        if (ln_err >= ln_ady) begin
          ln_err = ln_err - ln_ady;
          ln_x = ln_x + dir_offset(ln_dirx);
        end
        ln_y = ln_y + dir_offset(ln_diry);
      end
      ln_left = ln_left - 17'd1;
      if (ln_left == 0) ln_active = 1'b0;
      done = ln_left == 0;
      sides = ln_width > 1 ? ln_width - 1 : 0;
      n = 1 + 2 * sides;
      k = 0;
      // Thickness run: perpendicular to the major axis
      if (ln_horiz) begin
        pending_pixels.push_back(make_pixel(1'b1, ln_x, ln_y, ln_color, k == n - 1, done));
        k++;
      end
      for (j = 1; j <= sides; j++) begin
        if (ln_horiz) begin
          pending_pixels.push_back(make_pixel(1'b1, ln_x, ln_y + 16'(j), ln_color,
                                              k == n - 1, done));
          pending_pixels.push_back(make_pixel(1'b1, ln_x, ln_y - 16'(j), ln_color,
                                              k + 1 == n - 1, done));
        end else begin
          pending_pixels.push_back(make_pixel(1'b1, ln_x + 16'(j), ln_y, ln_color,
                                              k == n - 1, done));
          pending_pixels.push_back(make_pixel(1'b1, ln_x - 16'(j), ln_y, ln_color,
                                              k + 1 == n - 1, done));
        end
        k += 2;
      end
      if (!ln_horiz) begin
        pending_pixels.push_back(make_pixel(1'b1, ln_x, ln_y, ln_color, k == n - 1, done));
      end
    end
  endtask

  // Drive one request, wait for it to be taken, then predict its pixels
  task automatic send_request(input logic c, input logic signed [15:0] sx, sy, ex, ey,
                              input logic [15:0] col, input logic [5:0] w);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    cmd <= c;
    start_x <= sx;
    start_y <= sy;
    end_x <= ex;
    end_y <= ey;
    line_color <= col;
    line_width <= w;
    do @(posedge clk); while (in_stall);
    predict_pixels(c, sx, sy, ex, ey, col, w);
    if (c == CMD_START) n_starts++;
    else n_steps++;
  endtask

  task automatic send_steps(input int count);
    repeat (count)
      send_request(CMD_STEP, 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom), 6'($urandom_range(0, 63)));
  endtask

  // Steps with no line loaded, and a zero-length line
  task automatic test_idle_steps();
    send_steps(1);
    send_request(CMD_START, 9, 9, 9, 9, 16'h1234, 6'd3);
    send_steps(1);
  endtask

  // A positive x-major line, a negative y-major line, a diagonal tie, thin widths; one step past the end of the first
  task automatic test_octants();
    send_request(CMD_START, 0, 0, 3, 1, 16'hFFFF, 6'd1);
    send_steps(4);
    send_request(CMD_START, 0, 0, -2, -5, 16'h00A5, 6'd2);
    send_steps(2);
    send_request(CMD_START, 5, 5, 7, 7, 16'h5A00, 6'd0);
    send_steps(2);
  endtask

  // Full-range deltas, saturated thickness, thickness offsets wrapping at the edges
  task automatic test_extremes();
    send_request(CMD_START, -32768, -32768, 32767, 32767, 16'h0000, 6'd33);
    send_steps(2);
    send_request(CMD_START, 32767, 32766, 32760, 32767, 16'h8001, 6'd4);
    send_steps(1);
    send_request(CMD_START, -32768, 0, -32767, -3, 16'h7FFE, 6'd63);
    send_steps(1);
  endtask

  // Mostly well-formed short lines with random content, plus raw noise requests
  task automatic test_random_lines(input int n_items);
    int sent, dmax, ddx, ddy, major, nsteps;
    logic signed [15:0] sx, sy;
    logic [5:0] w;
    sent = 0;
    while (sent < n_items) begin
      stall_mode = stall_mode_t'((sent / 50) % 4);
      gaps_on = ((sent / 50) % 3) != 0;
      if ($urandom_range(0, 99) < 12) begin
        send_request(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom),
                     6'($urandom_range(0, 63)));
        sent++;
      end else begin
        dmax = ($urandom_range(0, 9) == 0) ? 300 : 10;
        ddx = $urandom_range(0, 2 * dmax) - dmax;
        ddy = $urandom_range(0, 2 * dmax) - dmax;
        sx = 16'($urandom);
        sy = 16'($urandom);
        w = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) :
                                          6'($urandom_range(0, 5));
        send_request(CMD_START, sx, sy, 16'(sx + ddx), 16'(sy + ddy), 16'($urandom), w);
        major = (ddx < 0 ? -ddx : ddx) > (ddy < 0 ? -ddy : ddy) ?
                (ddx < 0 ? -ddx : ddx) : (ddy < 0 ? -ddy : ddy);
        // run to the end, a bit past it, or abandon the line early
        if ($urandom_range(0, 3) == 0) nsteps = $urandom_range(0, major);
        else nsteps = major + $urandom_range(0, 2);
        if (nsteps > 24) nsteps = 24;
        send_steps(nsteps);
        sent += 1 + nsteps;
      end
    end
  endtask

  // Receiver holds off for a long stretch while steps keep coming
  task automatic test_backpressure();
    stall_mode = STALL_NONE;
    gaps_on = 1'b0;
    hold_tickets++;
    send_request(CMD_START, 100, -50, 120, -40, 16'hBEEF, 6'd8);
    send_steps(20);
    stall_mode = STALL_LIGHT;
  endtask

  // Receiver stall pattern, plus the counted hold-off
  int hold_seen = 0;
  int hold_left = 0;
  int stall_phase = 0;
  always @(negedge clk) begin
    if (hold_seen != hold_tickets) begin
      hold_seen = hold_tickets;
      hold_left = HOLD_CYCLES;
    end
    stall_phase = (stall_phase + 1) % 7;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE:    out_stall <= 1'b0;
        STALL_LIGHT:   out_stall <= ($urandom_range(0, 3) == 0);
        STALL_PATTERN: out_stall <= (stall_phase < 3);
        default:       out_stall <= ($urandom_range(0, 9) < 6);
      endcase
    end
  end

  task automatic report_field(input string name, input logic signed [31:0] exp_v, act_v);
    fail_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
  endtask

  // Compare each accepted pixel against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected pixel, expected none, actual valid=%0d x=%0d y=%0d",
                 $time, pixel_valid, pixel_x, pixel_y);
      end else begin
        want = pending_pixels.pop_front();
        if (want.valid) n_pixels++;
        else n_blank++;
        if (pixel_valid !== want.valid) report_field("pixel_valid", want.valid, pixel_valid);
        if (pixel_x !== want.x) report_field("pixel_x", want.x, pixel_x);
        if (pixel_y !== want.y) report_field("pixel_y", want.y, pixel_y);
        if (pixel_color !== want.color) report_field("pixel_color", want.color, pixel_color);
        if (last_of_step !== want.last) report_field("last_of_step", want.last, last_of_step);
        if (line_done !== want.done) report_field("line_done", want.done, line_done);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d pixels outstanding", $time, pending_pixels.size());
      $display("thick_line_rasterizer_core regression: fail");
      $finish;
    end
  end

  // Test sequence
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    stall_mode = STALL_LIGHT;
    test_idle_steps();
    test_octants();
    test_extremes();
    test_random_lines(310);
    test_backpressure();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d line starts and %0d steps: %0d drawn pixels, %0d idle-step results,",
             n_starts, n_steps, n_pixels, n_blank);
    $display("under varied sender gaps, output stalls and one long output hold-off.");
    if (fail_count == 0) begin
      $display("thick_line_rasterizer_core regression: pass");
    end else begin
      $display("thick_line_rasterizer_core regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/thlr_pkg.sv
rtl/thlr_step.sv
rtl/thlr_emit.sv
rtl/thick_line_rasterizer_core.sv
rtl/thlr_check.sv
tb/sv/tb_thick_line_rasterizer_core.sv
